// ===== src/font_face_best_match_select_macros.svh =====
// Assertion macros shared by the font face selection RTL.
`ifndef FONT_FACE_BEST_MATCH_SELECT_MACROS_SVH
`define FONT_FACE_BEST_MATCH_SELECT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FFBMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FFBMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ffbms_pkg.sv =====
// Package with widths, cost constants, codes and types of the font face selector.
package ffbms_pkg;

    // Field widths.
    localparam int WEIGHT_W  = 10;
    localparam int STYLE_W   = 2;
    localparam int STRETCH_W = 4;
    localparam int SEQ_W     = 32;
    localparam int SCORE_W   = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    // Style codes.
    localparam logic [STYLE_W-1:0] STYLE_NORMAL  = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_ITALIC  = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_OBLIQUE = 2'd2;

    // Penalty costs.
    localparam logic [SCORE_W-1:0] STYLE_FULL_COST         = 14'd10000;
    localparam logic [SCORE_W-1:0] STYLE_NEAR_COST         = 14'd5000;
    localparam logic [10:0]        STRETCH_STEP_COST       = 11'd100;
    localparam logic [SCORE_W-1:0] STRETCH_WRONG_SIDE_COST = 14'd1000;
    localparam logic [STRETCH_W-1:0] STRETCH_NORMAL        = 4'd5;

    // Largest score any bit pattern can give.
    localparam logic [SCORE_W-1:0] SCORE_MAX = 14'd13523;

    // Reset values of the request registers.
    localparam logic [WEIGHT_W-1:0]  RESET_WEIGHT  = 10'd400;
    localparam logic [STYLE_W-1:0]   RESET_STYLE   = STYLE_NORMAL;
    localparam logic [STRETCH_W-1:0] RESET_STRETCH = STRETCH_NORMAL;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQUEST_WEIGHT  = 2'd0,
        CFG_REQUEST_STYLE   = 2'd1,
        CFG_REQUEST_STRETCH = 2'd2
    } cfg_index_t;

    // Scored face handed to the running-best stage.
    typedef struct packed {
        logic               valid;
        logic               match;
        logic               last;
        logic [SCORE_W-1:0] score;
        logic [SEQ_W-1:0]   seq_num;
    } cand_t;

    // Result payload.
    typedef struct packed {
        logic               found;
        logic [SEQ_W-1:0]   best_sequence;
        logic [SCORE_W-1:0] best_score;
    } result_t;

endpackage

// ===== src/ffbms_if.sv =====
// Channel interfaces for face input beats and result beats.
interface ffbms_face_if;
    logic                                valid;
    logic                                ready;
    logic                                family_match;
    logic [ffbms_pkg::WEIGHT_W-1:0]      face_weight;
    logic [ffbms_pkg::STYLE_W-1:0]       face_style;
    logic [ffbms_pkg::STRETCH_W-1:0]     face_stretch;
    logic [ffbms_pkg::SEQ_W-1:0]         face_sequence;
    logic                                last_face;

    modport source (
        output valid, family_match, face_weight, face_style, face_stretch,
               face_sequence, last_face,
        input  ready
    );
    modport sink (
        input  valid, family_match, face_weight, face_style, face_stretch,
               face_sequence, last_face,
        output ready
    );
endinterface

interface ffbms_result_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [ffbms_pkg::SEQ_W-1:0]     best_sequence;
    logic [ffbms_pkg::SCORE_W-1:0]   best_score;

    modport source (
        output valid, found, best_sequence, best_score,
        input  ready
    );
    modport sink (
        input  valid, found, best_sequence, best_score,
        output ready
    );
endinterface

// ===== src/ffbms_score.sv =====
// Penalty score of one face against the requested weight, style and stretch.
module ffbms_score (
    input  logic [ffbms_pkg::WEIGHT_W-1:0]  face_weight,
    input  logic [ffbms_pkg::STYLE_W-1:0]   face_style,
    input  logic [ffbms_pkg::STRETCH_W-1:0] face_stretch,
    input  logic [ffbms_pkg::WEIGHT_W-1:0]  request_weight,
    input  logic [ffbms_pkg::STYLE_W-1:0]   request_style,
    input  logic [ffbms_pkg::STRETCH_W-1:0] request_stretch,
    output logic [ffbms_pkg::SCORE_W-1:0]   score
);

    logic [ffbms_pkg::SCORE_W-1:0]    style_cost;
    logic signed [ffbms_pkg::STRETCH_W:0] stretch_diff;
    logic [ffbms_pkg::STRETCH_W-1:0]  stretch_abs;
    logic [10:0]                      stretch_steps;
    logic                             preferred_side;
    logic [ffbms_pkg::SCORE_W-1:0]    stretch_cost;
    logic [ffbms_pkg::WEIGHT_W-1:0]   weight_diff;

    // Style: italic and oblique are near neighbors, anything else costs in full.
    always_comb
    begin
        if (face_style == request_style)
        begin
            style_cost = '0;
        end
        else if ((face_style == ffbms_pkg::STYLE_ITALIC &&
                  request_style == ffbms_pkg::STYLE_OBLIQUE) ||
                 (face_style == ffbms_pkg::STYLE_OBLIQUE &&
                  request_style == ffbms_pkg::STYLE_ITALIC))
        begin
            style_cost = ffbms_pkg::STYLE_NEAR_COST;
        end
        else
        begin
            style_cost = ffbms_pkg::STYLE_FULL_COST;
        end
    end

    // Stretch: steps cost 100 each, plus a fixed cost on the wrong side of normal.
    always_comb
    begin
        stretch_diff = signed'({1'b0, face_stretch}) - signed'({1'b0, request_stretch});
        stretch_abs  = stretch_diff[ffbms_pkg::STRETCH_W] ?
                       ffbms_pkg::STRETCH_W'(-stretch_diff) :
                       stretch_diff[ffbms_pkg::STRETCH_W-1:0];
        stretch_steps = 11'(stretch_abs) * ffbms_pkg::STRETCH_STEP_COST;
        preferred_side =
            (request_stretch < ffbms_pkg::STRETCH_NORMAL && stretch_diff[ffbms_pkg::STRETCH_W]) ||
            (request_stretch > ffbms_pkg::STRETCH_NORMAL && !stretch_diff[ffbms_pkg::STRETCH_W] &&
             stretch_diff != '0);
        if (stretch_diff == '0)
        begin
            stretch_cost = '0;
        end
        else if (preferred_side)
        begin
            stretch_cost = ffbms_pkg::SCORE_W'(stretch_steps);
        end
        else
        begin
            stretch_cost = ffbms_pkg::SCORE_W'(stretch_steps) +
                           ffbms_pkg::STRETCH_WRONG_SIDE_COST;
        end
    end

    // Weight: plain distance.
    assign weight_diff = (face_weight >= request_weight) ? (face_weight - request_weight)
                                                         : (request_weight - face_weight);

    assign score = style_cost + stretch_cost + ffbms_pkg::SCORE_W'(weight_diff);

endmodule

// ===== src/ffbms_best.sv =====
// Running best face and the result output register.
module ffbms_best (
    input  logic                clk,
    input  logic                rst_n,
    input  ffbms_pkg::cand_t    cand,
    output logic                cand_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output ffbms_pkg::result_t  result
);

    logic                          have_reg, have_next;
    logic [ffbms_pkg::SCORE_W-1:0] lowest_reg, lowest_next;
    logic [ffbms_pkg::SEQ_W-1:0]   winner_reg, winner_next;
    logic                          out_valid_reg, out_valid_next;
    ffbms_pkg::result_t            out_reg, out_next;
    logic                          take;
    logic                          wins;
    logic                          upd_have;
    logic [ffbms_pkg::SCORE_W-1:0] upd_lowest;
    logic [ffbms_pkg::SEQ_W-1:0]   upd_winner;

    // Only a last face needs the output register; other faces always pass.
    assign cand_ready = !cand.last || !out_valid_reg || result_ready;
    assign take       = cand.valid && cand_ready;

    // Compare against the running best; a tie goes to the later declaration.
    always_comb
    begin
        wins = cand.match &&
               (!have_reg || cand.score < lowest_reg ||
                (cand.score == lowest_reg && cand.seq_num > winner_reg));
        upd_have   = have_reg || wins;
        upd_lowest = wins ? cand.score : lowest_reg;
        upd_winner = wins ? cand.seq_num : winner_reg;
    end

    // Next state of the running best and of the output register.
    always_comb
    begin
        have_next      = have_reg;
        lowest_next    = lowest_reg;
        winner_next    = winner_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        if (take)
        begin
            if (cand.last)
            begin
                have_next              = 1'b0;
                lowest_next            = '0;
                winner_next            = '0;
                out_valid_next         = 1'b1;
                out_next.found         = upd_have;
                out_next.best_sequence = upd_have ? upd_winner : '0;
                out_next.best_score    = upd_have ? upd_lowest : '0;
            end
            else
            begin
                have_next   = upd_have;
                lowest_next = upd_lowest;
                winner_next = upd_winner;
            end
        end
    end

    // Control state and running best.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg      <= 1'b0;
            lowest_reg    <= '0;
            winner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            have_reg      <= have_next;
            lowest_reg    <= lowest_next;
            winner_reg    <= winner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== src/font_face_best_match_select.sv =====
// Top level of the CSS-style best font face selector.
//
//  Channel  Direction  Beat contents
//  face     in         family_match, face_weight, face_style, face_stretch,
//                      face_sequence, last_face
//  result   out        found, best_sequence, best_score
//  cfg_*    in         request_weight, request_style, request_stretch writes
//
// One face beat is taken every cycle unless a waiting result stalls the input; scoring
// and the running-best compare are combinational between the input register and the result register.
// A result beat is registered: its last face passes the input register, then the result register.
// Reset clears the input register, the running best and loads the default request.
// A waiting result stalls the input only when a last face sits in the input register.
`include "font_face_best_match_select_macros.svh"

module font_face_best_match_select (
    input  logic                               clk,
    input  logic                               rst_n,
    ffbms_face_if.sink                         face,
    ffbms_result_if.source                     result,
    input  logic                               cfg_write,
    input  logic [ffbms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffbms_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [ffbms_pkg::WEIGHT_W-1:0]  req_weight_reg;
    logic [ffbms_pkg::STYLE_W-1:0]   req_style_reg;
    logic [ffbms_pkg::STRETCH_W-1:0] req_stretch_reg;

    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_match_reg;
    logic [ffbms_pkg::WEIGHT_W-1:0]  s1_weight_reg;
    logic [ffbms_pkg::STYLE_W-1:0]   s1_style_reg;
    logic [ffbms_pkg::STRETCH_W-1:0] s1_stretch_reg;
    logic [ffbms_pkg::SEQ_W-1:0]     s1_sequence_reg;
    logic                            s1_last_reg;

    ffbms_pkg::cand_t                cand;
    logic [ffbms_pkg::SCORE_W-1:0]   s1_score;
    logic                            best_ready;
    ffbms_pkg::result_t              best_result;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_weight_reg  <= ffbms_pkg::RESET_WEIGHT;
            req_style_reg   <= ffbms_pkg::RESET_STYLE;
            req_stretch_reg <= ffbms_pkg::RESET_STRETCH;
        end
        else if (cfg_write)
        begin
            case (ffbms_pkg::cfg_index_t'(cfg_index))
                ffbms_pkg::CFG_REQUEST_WEIGHT:
                    req_weight_reg <= cfg_data[ffbms_pkg::WEIGHT_W-1:0];
                ffbms_pkg::CFG_REQUEST_STYLE:
                    req_style_reg <= cfg_data[ffbms_pkg::STYLE_W-1:0];
                ffbms_pkg::CFG_REQUEST_STRETCH:
                    req_stretch_reg <= cfg_data[ffbms_pkg::STRETCH_W-1:0];
                default:
                    req_weight_reg <= req_weight_reg;
            endcase
        end
    end

    // The input register frees up whenever the running-best stage takes its face.
    assign face.ready    = !s1_valid_reg || best_ready;
    assign s1_valid_next = face.ready ? face.valid : s1_valid_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (face.valid && face.ready)
        begin
            s1_match_reg    <= face.family_match;
            s1_weight_reg   <= face.face_weight;
            s1_style_reg    <= face.face_style;
            s1_stretch_reg  <= face.face_stretch;
            s1_sequence_reg <= face.face_sequence;
            s1_last_reg     <= face.last_face;
        end
    end

    // Face scoring.
    ffbms_score u_score (
        .face_weight     (s1_weight_reg),
        .face_style      (s1_style_reg),
        .face_stretch    (s1_stretch_reg),
        .request_weight  (req_weight_reg),
        .request_style   (req_style_reg),
        .request_stretch (req_stretch_reg),
        .score           (s1_score)
    );

    // Scored face offered to the running-best stage.
    always_comb
    begin
        cand.valid   = s1_valid_reg;
        cand.match   = s1_match_reg;
        cand.last    = s1_last_reg;
        cand.score   = s1_score;
        cand.seq_num = s1_sequence_reg;
    end

    // Running best and result register.
    ffbms_best u_best (
        .clk          (clk),
        .rst_n        (rst_n),
        .cand         (cand),
        .cand_ready   (best_ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .result       (best_result)
    );

    assign result.found         = best_result.found;
    assign result.best_sequence = best_result.best_sequence;
    assign result.best_score    = best_result.best_score;

    // Checks on the scored face and the result.
    `FFBMS_ASSERT_NOW(a_score_bound, clk, rst_n, cand.valid && cand.match,
        cand.score <= ffbms_pkg::SCORE_MAX, "face score out of range")
    `FFBMS_ASSERT_NEXT(a_last_gives_result, clk, rst_n,
        cand.valid && best_ready && cand.last, result.valid,
        "last face taken without a result")
    `FFBMS_ASSERT_NOW(a_empty_result_zero, clk, rst_n, result.valid && !result.found,
        result.best_sequence == '0 && result.best_score == '0,
        "empty result carries nonzero payload")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the font face best match selector with its own scoring predictor.
module tb_top;
    import ffbms_pkg::*;

    // Style code outside the defined set; it is scored as a full mismatch unless the request holds the same code.
    localparam logic [STYLE_W-1:0] STYLE_UNDEFINED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ffbms_face_if face_ch ();
    ffbms_result_if result_ch ();

    font_face_best_match_select dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .face      (face_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Copy of the request registers and the running best, as the block should hold them.
    logic [WEIGHT_W-1:0]  want_weight  = RESET_WEIGHT;
    logic [STYLE_W-1:0]   want_style   = RESET_STYLE;
    logic [STRETCH_W-1:0] want_stretch = RESET_STRETCH;
    logic                 best_valid   = 1'b0;
    logic [SCORE_W-1:0]   best_penalty = '0;
    logic [SEQ_W-1:0]     best_seq     = '0;

    result_t pending_results[$];
    int mismatches = 0;
    int faces_sent = 0;
    int cycles = 0;

    // Idle controls shared between the test tasks and the two channel processes.
    bit send_idle = 1'b0;
    bit recv_idle = 1'b0;
    int stall_left = 0;
    int hold_left = 0;

    // Penalty of one face against the current request.
    function automatic logic [SCORE_W-1:0] face_penalty(input logic [WEIGHT_W-1:0] w,
                                                        input logic [STYLE_W-1:0] st,
                                                        input logic [STRETCH_W-1:0] sr);
        int total;
        int d;
        int ad;
        total = 0;
        if (st != want_style)
        begin
            if ((st == STYLE_ITALIC && want_style == STYLE_OBLIQUE) ||
                (st == STYLE_OBLIQUE && want_style == STYLE_ITALIC))
                total += int'(STYLE_NEAR_COST);
            else
                total += int'(STYLE_FULL_COST);
        end
        d = int'(sr) - int'(want_stretch);
        ad = (d < 0) ? -d : d;
        if (d != 0)
        begin
            // Moving toward the side the request already leans to is the cheap direction.
            if ((int'(want_stretch) < int'(STRETCH_NORMAL) && d < 0) ||
                (int'(want_stretch) > int'(STRETCH_NORMAL) && d > 0))
                total += ad * int'(STRETCH_STEP_COST);
            else
                total += ad * int'(STRETCH_STEP_COST) + int'(STRETCH_WRONG_SIDE_COST);
        end
        total += (w >= want_weight) ? int'(w - want_weight) : int'(want_weight - w);
        return total[SCORE_W-1:0];
    endfunction

    // Fold one accepted face into the running best; a last face closes the query.
    task automatic fold_face(input logic hit, input logic [WEIGHT_W-1:0] w,
                             input logic [STYLE_W-1:0] st, input logic [STRETCH_W-1:0] sr,
                             input logic [SEQ_W-1:0] seq, input logic last);
        logic [SCORE_W-1:0] p;
        result_t r;
        if (hit)
        begin
            p = face_penalty(w, st, sr);
            if (!best_valid || p < best_penalty || (p == best_penalty && seq > best_seq))
            begin
                best_valid = 1'b1;
                best_penalty = p;
                best_seq = seq;
            end
        end
        if (last)
        begin
            r.found = best_valid;
            r.best_sequence = best_valid ? best_seq : '0;
            r.best_score = best_valid ? best_penalty : '0;
            pending_results.push_back(r);
            best_valid = 1'b0;
            best_penalty = '0;
            best_seq = '0;
        end
    endtask

    // Offer one face beat, after a random gap when send_idle is set, and wait until it is taken.
    task automatic send_face(input logic hit, input logic [WEIGHT_W-1:0] w,
                             input logic [STYLE_W-1:0] st, input logic [STRETCH_W-1:0] sr,
                             input logic [SEQ_W-1:0] seq, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            face_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        face_ch.valid = 1'b1;
        face_ch.family_match = hit;
        face_ch.face_weight = w;
        face_ch.face_style = st;
        face_ch.face_stretch = sr;
        face_ch.face_sequence = seq;
        face_ch.last_face = last;
        do @(posedge clk); while (!face_ch.ready);
        fold_face(hit, w, st, sr, seq, last);
        faces_sent++;
    endtask

    // Single register write; the block takes it at the next rising edge.
    task automatic write_request(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        case (idx)
            CFG_REQUEST_WEIGHT:  want_weight = data;
            CFG_REQUEST_STYLE:   want_style = data[STYLE_W-1:0];
            CFG_REQUEST_STRETCH: want_stretch = data[STRETCH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Stop offering faces, wait for every outstanding result, then let the pipe empty.
    task automatic settle();
        @(negedge clk);
        face_ch.valid = 1'b0;
        while (pending_results.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_request(input logic [WEIGHT_W-1:0] w, input logic [STYLE_W-1:0] st,
                               input logic [STRETCH_W-1:0] sr);
        settle();
        write_request(CFG_REQUEST_WEIGHT, CFG_DATA_W'(w));
        write_request(CFG_REQUEST_STYLE, CFG_DATA_W'(st));
        write_request(CFG_REQUEST_STRETCH, CFG_DATA_W'(sr));
    endtask

    // One query of random faces; repeated attributes and small sequences provoke ties.
    task automatic random_query(input int faces);
        logic hit;
        logic [WEIGHT_W-1:0] w;
        logic [STYLE_W-1:0] st;
        logic [STRETCH_W-1:0] sr;
        logic [SEQ_W-1:0] seq;
        w = '0;
        st = STYLE_NORMAL;
        sr = STRETCH_NORMAL;
        for (int i = 0; i < faces; i++)
        begin
            hit = ($urandom_range(0, 4) != 0);
            if (i == 0 || $urandom_range(0, 4) != 0)
            begin
                w = WEIGHT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(1, 1000));
                if ($urandom_range(0, 15) == 0)
                    st = STYLE_UNDEFINED;
                else
                    st = STYLE_W'($urandom_range(0, 2));
                sr = STRETCH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(1, 9));
            end
            seq = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom();
            send_face(hit, w, st, sr, seq, i == faces - 1);
        end
    endtask

    // Queries where no face belongs to the family report nothing found.
    task automatic test_no_match();
        send_face(1'b0, 10'd1023, STYLE_UNDEFINED, 4'd15, 32'hFFFF_FFFF, 1'b0);
        send_face(1'b0, 10'd0, STYLE_NORMAL, 4'd0, 32'd0, 1'b1);
        send_face(1'b0, 10'd400, STYLE_NORMAL, 4'd5, 32'd7, 1'b1);
    endtask

    // Single-face queries at the extremes of weight, stretch, style and sequence.
    task automatic test_field_extremes();
        send_face(1'b1, 10'd1, STYLE_NORMAL, 4'd1, 32'd0, 1'b1);
        send_face(1'b1, 10'd1000, STYLE_OBLIQUE, 4'd9, 32'hFFFF_FFFF, 1'b1);
        send_face(1'b1, 10'd0, STYLE_UNDEFINED, 4'd0, 32'h5555_5555, 1'b1);
        send_face(1'b1, 10'd1023, STYLE_ITALIC, 4'd15, 32'hAAAA_AAAA, 1'b1);
    endtask

    // Style costs: full mismatch and the italic and oblique pair.
    task automatic test_style_costs();
        send_face(1'b1, 10'd400, STYLE_ITALIC, 4'd5, 32'd1, 1'b1);
        send_face(1'b1, 10'd400, STYLE_OBLIQUE, 4'd5, 32'd2, 1'b1);
        set_request(10'd400, STYLE_ITALIC, 4'd5);
        send_face(1'b1, 10'd400, STYLE_OBLIQUE, 4'd5, 32'd3, 1'b1);
        send_face(1'b1, 10'd400, STYLE_NORMAL, 4'd5, 32'd4, 1'b1);
        set_request(10'd400, STYLE_OBLIQUE, 4'd5);
        send_face(1'b1, 10'd400, STYLE_ITALIC, 4'd5, 32'd5, 1'b1);
    endtask

    // Stretch costs on the preferred and the wrong side of a narrow and a wide request.
    task automatic test_stretch_sides();
        set_request(10'd400, STYLE_NORMAL, 4'd3);
        send_face(1'b1, 10'd400, STYLE_NORMAL, 4'd1, 32'd6, 1'b1);
        send_face(1'b1, 10'd400, STYLE_NORMAL, 4'd6, 32'd7, 1'b1);
        set_request(10'd400, STYLE_NORMAL, 4'd7);
        send_face(1'b1, 10'd400, STYLE_NORMAL, 4'd9, 32'd8, 1'b1);
        send_face(1'b1, 10'd400, STYLE_NORMAL, 4'd4, 32'd9, 1'b1);
    endtask

    // Equal scores go to the higher sequence; the first matching face is always taken.
    task automatic test_tie_break();
        set_request(10'd500, STYLE_NORMAL, 4'd5);
        send_face(1'b1, 10'd600, STYLE_NORMAL, 4'd5, 32'd5, 1'b0);
        send_face(1'b1, 10'd400, STYLE_NORMAL, 4'd5, 32'd9, 1'b0);
        send_face(1'b1, 10'd600, STYLE_NORMAL, 4'd5, 32'd2, 1'b1);
        send_face(1'b1, 10'd500, STYLE_NORMAL, 4'd5, 32'd0, 1'b0);
        send_face(1'b1, 10'd501, STYLE_NORMAL, 4'd5, 32'd100, 1'b1);
    endtask

    // Random queries under a series of request settings, the extremes among them.
    task automatic test_random_requests();
        int phase_end;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_request(RESET_WEIGHT, RESET_STYLE, RESET_STRETCH);
                1: set_request(10'd1, STYLE_NORMAL, 4'd1);
                2: set_request(10'd1000, STYLE_OBLIQUE, 4'd9);
                3: set_request(10'd0, STYLE_UNDEFINED, 4'd15);
                4: set_request(10'd1023, STYLE_ITALIC, 4'd0);
                default: set_request(WEIGHT_W'($urandom_range(1, 1000)),
                                     STYLE_W'($urandom_range(0, 2)),
                                     STRETCH_W'($urandom_range(1, 9)));
            endcase
            phase_end = faces_sent + 100;
            while (faces_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_idle = ~send_idle;
                if ($urandom_range(0, 9) == 0)
                    recv_idle = ~recv_idle;
                random_query(($urandom_range(0, 9) == 0) ? $urandom_range(1, 12)
                                                         : $urandom_range(1, 6));
            end
        end
    endtask

    // Long receiver hold-off while faces keep coming, then a sender pause to drain.
    task automatic test_result_backpressure();
        set_request(WEIGHT_W'($urandom_range(1, 1000)), STYLE_W'($urandom_range(0, 2)),
                    STRETCH_W'($urandom_range(1, 9)));
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_left = 300;
        repeat (25) random_query($urandom_range(1, 3));
        settle();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (8) random_query($urandom_range(1, 3));
    endtask

    // Result checker: each beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_ch.found !== exp_r.found)
                begin
                    $error("found: expected %0d, got %0d", exp_r.found, result_ch.found);
                    mismatches++;
                end
                if (result_ch.best_sequence !== exp_r.best_sequence)
                begin
                    $error("best_sequence: expected %0d, got %0d",
                           exp_r.best_sequence, result_ch.best_sequence);
                    mismatches++;
                end
                if (result_ch.best_score !== exp_r.best_score)
                begin
                    $error("best_score: expected %0d, got %0d",
                           exp_r.best_score, result_ch.best_score);
                    mismatches++;
                end
            end
            stall_left = recv_idle ? $urandom_range(0, 8) : 0;
        end
    end

    // Result ready: a long hold-off first, then the per-beat stall.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready = 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_REQUEST_WEIGHT;
        cfg_data = '0;
        face_ch.valid = 1'b0;
        face_ch.family_match = 1'b0;
        face_ch.face_weight = '0;
        face_ch.face_style = STYLE_NORMAL;
        face_ch.face_stretch = '0;
        face_ch.face_sequence = '0;
        face_ch.last_face = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_match();
        test_field_extremes();
        test_style_costs();
        test_stretch_sides();
        test_tie_break();
        test_random_requests();
        test_result_backpressure();
        settle();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
